### rtl/bcss_pkg.sv
// Shared definitions for the circular bitmap scroll store.
// Holds command codes, register indexes, reset values and the control struct.
// No dependencies.
`default_nettype none

package bcss_pkg;

    // Default store dimensions.
    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;

    // Field widths of the command interface.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 5;
    localparam int CFG_W   = 6;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UP     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DOWN   = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_ACTIVE_WIDTH  = 6'd32;
    localparam logic [CFG_W-1:0] RST_ACTIVE_HEIGHT = 6'd32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;     // Apply the command on the input ports this cycle.
    } t_dp_ctrl;

endpackage

`default_nettype wire

### rtl/bcss_ctrl.sv
// Controller of the circular bitmap scroll store.
// Sequences command acceptance and the result strobe. Depends on bcss_pkg.
`default_nettype none

module bcss_ctrl
    import bcss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    output logic          o_done,
    output t_dp_ctrl      o_dp_ctrl
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic r_state;
    logic n_state;

    // Next-state logic: a command executes on its transfer edge, then the
    // result is shown for one cycle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs decoded from the state.
    assign o_busy         = (r_state == ST_RESP);
    assign o_done         = (r_state == ST_RESP);
    assign o_dp_ctrl.exec = (r_state == ST_IDLE) && i_start;

endmodule

`default_nettype wire

### rtl/bcss_datapath.sv
// Datapath of the circular bitmap scroll store: the bitmap registers,
// the active-size registers, rotation and bit access logic. Depends on bcss_pkg.
`default_nettype none

module bcss_datapath
    import bcss_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_ctrl           i_dp_ctrl,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [INDEX_W-1:0] i_row_index,
    input  wire logic [INDEX_W-1:0] i_col_index,
    input  wire logic               i_write_value,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    output logic                    o_read_bit
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [MAX_WIDTH-1:0] r_rows [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] n_rows [MAX_HEIGHT];
    logic [CFG_W-1:0]     r_active_width;
    logic [CFG_W-1:0]     r_active_height;
    logic                 r_read_bit;
    logic                 n_read_bit;

    logic [WW-1:0]        eff_w;
    logic [HW-1:0]        eff_h;
    logic [31:0]          sel_idx;
    logic [MAX_WIDTH-1:0] sel_row;
    logic [MAX_WIDTH-1:0] last_mask;

    // Active sizes saturate at the store dimensions.
    assign eff_w = (32'(r_active_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_active_width);
    assign eff_h = (32'(r_active_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_active_height);

    // Single row read port: the addressed row for a read, the last active
    // row for a downward rotation.
    always_comb begin
        if (i_cmd == CMD_DOWN) begin
            sel_idx = 32'(eff_h) - 32'd1;
        end else begin
            sel_idx = 32'(i_row_index);
        end
        sel_row = '0;
        for (int r = 0; r < MAX_HEIGHT; r++) begin
            if (sel_idx == 32'(r)) begin
                sel_row = r_rows[r];
            end
        end
    end

    // Mask of the last active column, used to wrap a right rotation.
    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            last_mask[c] = (32'(eff_w) != 32'd0) && (32'(c) == 32'(eff_w) - 32'd1);
        end
    end

    // Next bitmap and read result.
    always_comb begin
        int  cu;
        int  cd;
        int  ru;
        int  rd;
        logic act;

        n_read_bit = 1'b0;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            if ((i_cmd == CMD_READ) && (32'(i_col_index) == 32'(c))) begin
                n_read_bit = sel_row[c];
            end
        end

        for (int r = 0; r < MAX_HEIGHT; r++) begin
            ru = (r == MAX_HEIGHT - 1) ? 0 : r + 1;
            rd = (r == 0) ? 0 : r - 1;
            n_rows[r] = r_rows[r];
            for (int c = 0; c < MAX_WIDTH; c++) begin
                cu  = (c == MAX_WIDTH - 1) ? 0 : c + 1;
                cd  = (c == 0) ? 0 : c - 1;
                act = (32'(r) < 32'(eff_h)) && (32'(c) < 32'(eff_w));
                unique case (i_cmd)
                    CMD_WRITE: begin
                        if ((32'(i_row_index) == 32'(r)) && (32'(i_col_index) == 32'(c))) begin
                            n_rows[r][c] = i_write_value;
                        end
                    end
                    CMD_LEFT: begin
                        if (act) begin
                            n_rows[r][c] = (32'(c) == 32'(eff_w) - 32'd1) ?
                                           r_rows[r][0] : r_rows[r][cu];
                        end
                    end
                    CMD_RIGHT: begin
                        if (act) begin
                            n_rows[r][c] = (c == 0) ? |(r_rows[r] & last_mask) :
                                           r_rows[r][cd];
                        end
                    end
                    CMD_UP: begin
                        if (act) begin
                            n_rows[r][c] = (32'(r) == 32'(eff_h) - 32'd1) ?
                                           r_rows[0][c] : r_rows[ru][c];
                        end
                    end
                    CMD_DOWN: begin
                        if (act) begin
                            n_rows[r][c] = (r == 0) ? sel_row[c] : r_rows[rd][c];
                        end
                    end
                    default: begin
                        n_rows[r][c] = r_rows[r][c];
                    end
                endcase
            end
        end
    end

    // Bitmap store, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_HEIGHT; r++) begin
                r_rows[r] <= '0;
            end
        end else if (i_dp_ctrl.exec) begin
            for (int r = 0; r < MAX_HEIGHT; r++) begin
                r_rows[r] <= n_rows[r];
            end
        end
    end

    // Result register, loaded on each command transfer.
    always_ff @(posedge i_clk) begin
        if (i_dp_ctrl.exec) begin
            r_read_bit <= n_read_bit;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= RST_ACTIVE_WIDTH;
            r_active_height <= RST_ACTIVE_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_wdata;
                CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_wdata;
                default: begin
                    r_active_width <= r_active_width;
                end
            endcase
        end
    end

    assign o_read_bit = r_read_bit;

endmodule

`default_nettype wire

### rtl/bitmap_circular_scroll_store_unit.sv
// Top level of the circular bitmap scroll store.
// Instantiates bcss_ctrl and bcss_datapath. Depends on bcss_pkg.
//
// Usage:
//   A command (i_cmd, i_row_index, i_col_index, i_write_value) transfers on a
//   rising edge where start is high and busy is low. Commands are read,
//   write, and rotate the active region left, right, up or down by one.
//   The command takes effect on the bitmap at its transfer edge. In the
//   following cycle o_done is high for exactly one cycle with o_read_bit:
//   the addressed bit for a read, zero otherwise. The receiver takes the
//   result at the edge that ends that cycle and cannot hold it off.
//   A new command cannot transfer while the result is shown: the
//   controller's response state keeps busy high during it.
//   The active size comes from i_cfg_* writes (index 0 width, index 1
//   height), taken at any edge with i_cfg_we high; the user must write
//   them only while idle, which the block itself does not enforce.
//   Synchronous reset clears the whole bitmap at once, sets both active
//   sizes to 32 and returns the controller to idle.
`default_nettype none

module bitmap_circular_scroll_store_unit
    import bcss_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [CMD_W-1:0]   i_cmd,
    input  wire logic [INDEX_W-1:0] i_row_index,
    input  wire logic [INDEX_W-1:0] i_col_index,
    input  wire logic               i_write_value,
    output logic                    o_done,
    output logic                    o_read_bit,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata
);

    t_dp_ctrl dp_ctrl;

    // Command sequencing.
    bcss_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_dp_ctrl (dp_ctrl)
    );

    // Bitmap store and configuration.
    bcss_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_ctrl     (dp_ctrl),
        .i_cmd         (i_cmd),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_read_bit    (o_read_bit)
    );

endmodule

`default_nettype wire

### tb/tb_bitmap_circular_scroll_store_unit.sv
// Self-checking testbench for the circular bitmap scroll store unit.
// A directed table and random phases are checked against a bitmap predictor.
// Depends on bcss_pkg and bitmap_circular_scroll_store_unit.
module tb_bitmap_circular_scroll_store_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bcss_pkg::*;

    // Codes outside the command set; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam int STORE_W     = DEF_MAX_WIDTH;
    localparam int STORE_H     = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;

    // One row of the directed table: a register write or a command.
    typedef struct {
        logic               is_reg;
        logic               reg_idx;
        logic [CFG_W-1:0]   reg_val;
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        logic               val;
        logic               fixed;
        logic               fixed_bit;
    } t_step;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd;
    logic [INDEX_W-1:0] i_row_index;
    logic [INDEX_W-1:0] i_col_index;
    logic               i_write_value;
    logic               o_done;
    logic               o_read_bit;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_wdata;

    // Predicted bitmap and active size.
    logic [STORE_W-1:0] pix_rows [STORE_H];
    logic [CFG_W-1:0]   act_width;
    logic [CFG_W-1:0]   act_height;

    logic  expected_read_bits [$];
    t_step directed_steps [$];
    int    fail_count;
    int    cycle_count;
    logic  exp_bit;

    bitmap_circular_scroll_store_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .o_done        (o_done),
        .o_read_bit    (o_read_bit),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock: 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Apply one command to the predicted bitmap and return the expected read bit.
    function automatic logic apply_pixel_cmd(input logic [CMD_W-1:0] cmd,
                                             input logic [INDEX_W-1:0] row,
                                             input logic [INDEX_W-1:0] col,
                                             input logic val);
        int                 w;
        int                 h;
        int                 r;
        logic [STORE_W-1:0] m;
        logic [STORE_W-1:0] seg;
        logic [STORE_W-1:0] nseg;
        logic [STORE_W-1:0] keep;
        logic               rd_bit;
        rd_bit = 1'b0;
        w = (act_width > STORE_W) ? STORE_W : int'(act_width);
        h = (act_height > STORE_H) ? STORE_H : int'(act_height);
        m = (w >= STORE_W) ? '1 : ((STORE_W'(1) << w) - 1);
        case (cmd)
            CMD_READ: begin
                rd_bit = pix_rows[row][col];
            end
            CMD_WRITE: begin
                pix_rows[row][col] = val;
            end
            CMD_LEFT, CMD_RIGHT: begin
                if (w != 0) begin
                    for (r = 0; r < h; r++) begin
                        seg = pix_rows[r] & m;
                        if (cmd == CMD_LEFT)
                            nseg = (seg >> 1) | (STORE_W'(seg[0]) << (w - 1));
                        else
                            nseg = (seg << 1) | (seg >> (w - 1));
                        pix_rows[r] = (pix_rows[r] & ~m) | (nseg & m);
                    end
                end
            end
            CMD_UP: begin
                if (w != 0 && h != 0) begin
                    keep = pix_rows[0] & m;
                    for (r = 0; r < h - 1; r++)
                        pix_rows[r] = (pix_rows[r] & ~m) | (pix_rows[r + 1] & m);
                    pix_rows[h - 1] = (pix_rows[h - 1] & ~m) | keep;
                end
            end
            CMD_DOWN: begin
                if (w != 0 && h != 0) begin
                    keep = pix_rows[h - 1] & m;
                    for (r = h - 1; r > 0; r--)
                        pix_rows[r] = (pix_rows[r] & ~m) | (pix_rows[r - 1] & m);
                    pix_rows[0] = (pix_rows[0] & ~m) | keep;
                end
            end
            default: begin
            end
        endcase
        return rd_bit;
    endfunction

    // Result checker: every strobed result is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_read_bits.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("Unexpected result transfer: read_bit=%0b", o_read_bit);
            end else begin
                exp_bit = expected_read_bits.pop_front();
                if (o_read_bit !== exp_bit) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("read_bit mismatch: expected %0b, got %0b",
                                 exp_bit, o_read_bit);
                end
            end
        end
    end

    function automatic void add_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic [INDEX_W-1:0] row,
                                    input logic [INDEX_W-1:0] col,
                                    input logic val, input logic fixed,
                                    input logic fixed_bit);
        t_step s;
        s.is_reg    = 1'b0;
        s.reg_idx   = CFG_ACTIVE_WIDTH;
        s.reg_val   = '0;
        s.cmd       = cmd;
        s.row       = row;
        s.col       = col;
        s.val       = val;
        s.fixed     = fixed;
        s.fixed_bit = fixed_bit;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_reg(input logic idx, input logic [CFG_W-1:0] value);
        t_step s;
        s.is_reg    = 1'b1;
        s.reg_idx   = idx;
        s.reg_val   = value;
        s.cmd       = CMD_READ;
        s.row       = '0;
        s.col       = '0;
        s.val       = 1'b0;
        s.fixed     = 1'b0;
        s.fixed_bit = 1'b0;
        directed_steps.push_back(s);
    endfunction

    // Mostly short gaps, a few long ones; none during a burst.
    function automatic int gap_cycles(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic idle_gap(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present a command and hold it until the transfer, then record the expectation.
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd,
                             input logic [INDEX_W-1:0] row,
                             input logic [INDEX_W-1:0] col,
                             input logic val, input logic fixed, input logic fixed_bit);
        logic predicted;
        start         <= 1'b1;
        i_cmd         <= cmd;
        i_row_index   <= row;
        i_col_index   <= col;
        i_write_value <= val;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predicted = apply_pixel_cmd(cmd, row, col, val);
        expected_read_bits.push_back(fixed ? fixed_bit : predicted);
    endtask

    // Stop issuing and wait until every expected result has come back.
    task automatic drain;
        start <= 1'b0;
        while (expected_read_bits.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register write; the predictor follows at the write edge.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        if (idx == CFG_ACTIVE_WIDTH)
            act_width = value;
        else
            act_height = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Width or height for a random phase: mostly inside the store, sometimes extreme.
    function automatic logic [CFG_W-1:0] pick_size;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CFG_W'($urandom_range(0, 63));
        if (r == 1)
            return CFG_W'(STORE_W);
        return CFG_W'($urandom_range(1, 32));
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CMD_READ;
        if (r < 68)
            return CMD_WRITE;
        if (r < 96) begin
            case ($urandom_range(0, 3))
                0:       return CMD_LEFT;
                1:       return CMD_RIGHT;
                2:       return CMD_UP;
                default: return CMD_DOWN;
            endcase
        end
        return $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
    endfunction

    initial begin
        t_step                s;
        logic [CFG_W-1:0]     phase_w;
        logic [CFG_W-1:0]     phase_h;
        bit                   burst;
        int                   p;
        int                   k;

        fail_count    = 0;
        cycle_count   = 0;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_cmd         <= CMD_READ;
        i_row_index   <= '0;
        i_col_index   <= '0;
        i_write_value <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_ACTIVE_WIDTH;
        i_cfg_wdata   <= '0;
        for (k = 0; k < STORE_H; k++)
            pix_rows[k] = '0;
        act_width  = RST_ACTIVE_WIDTH;
        act_height = RST_ACTIVE_HEIGHT;

        // Directed table: reset contents, corners, each rotation, unknown codes
        // and the degenerate active sizes.
        add_cmd(CMD_READ, 0, 0, 0, 1, 0);
        add_cmd(CMD_READ, 31, 31, 1, 1, 0);
        add_cmd(CMD_WRITE, 0, 0, 1, 1, 0);
        add_cmd(CMD_WRITE, 31, 31, 1, 1, 0);
        add_cmd(CMD_WRITE, 0, 31, 1, 1, 0);
        add_cmd(CMD_WRITE, 31, 0, 1, 1, 0);
        add_cmd(CMD_READ, 31, 31, 0, 1, 1);
        add_cmd(CMD_READ, 0, 31, 0, 1, 1);
        add_cmd(CMD_LEFT, 0, 0, 0, 0, 0);
        add_cmd(CMD_READ, 0, 30, 0, 0, 0);
        add_cmd(CMD_RIGHT, 31, 31, 1, 0, 0);
        add_cmd(CMD_UP, 0, 0, 0, 0, 0);
        add_cmd(CMD_READ, 30, 0, 0, 0, 0);
        add_cmd(CMD_DOWN, 0, 0, 0, 0, 0);
        add_cmd(CMD_UNUSED_6, 31, 31, 1, 1, 0);
        add_cmd(CMD_UNUSED_7, 0, 31, 1, 1, 0);
        add_reg(CFG_ACTIVE_WIDTH, 1);
        add_cmd(CMD_LEFT, 0, 0, 0, 0, 0);
        add_reg(CFG_ACTIVE_HEIGHT, 1);
        add_cmd(CMD_UP, 0, 0, 0, 0, 0);
        add_reg(CFG_ACTIVE_WIDTH, 0);
        add_cmd(CMD_RIGHT, 0, 0, 0, 0, 0);
        add_reg(CFG_ACTIVE_HEIGHT, 0);
        add_cmd(CMD_DOWN, 0, 0, 0, 0, 0);
        add_reg(CFG_ACTIVE_WIDTH, 63);
        add_reg(CFG_ACTIVE_HEIGHT, 63);
        add_cmd(CMD_DOWN, 0, 0, 0, 0, 0);
        add_cmd(CMD_READ, 0, 0, 0, 0, 0);
        add_reg(CFG_ACTIVE_WIDTH, 5);
        add_reg(CFG_ACTIVE_HEIGHT, 3);
        add_cmd(CMD_WRITE, 2, 4, 1, 1, 0);
        add_cmd(CMD_LEFT, 0, 0, 0, 0, 0);
        add_cmd(CMD_UP, 0, 0, 0, 0, 0);
        add_cmd(CMD_READ, 1, 3, 0, 0, 0);
        add_cmd(CMD_WRITE, 31, 31, 0, 1, 0);

        // Hold synchronous reset, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table.
        foreach (directed_steps[i]) begin
            s = directed_steps[i];
            if (s.is_reg) begin
                drain();
                write_reg(s.reg_idx, s.reg_val);
            end else begin
                issue_cmd(s.cmd, s.row, s.col, s.val, s.fixed, s.fixed_bit);
                idle_gap(gap_cycles(0));
            end
        end

        // Random phases, each with its own active size; the first few are extremes.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin phase_w = 32; phase_h = 32; end
                1:       begin phase_w = 1;  phase_h = 32; end
                2:       begin phase_w = 32; phase_h = 1;  end
                3:       begin phase_w = 0;  phase_h = 0;  end
                4:       begin phase_w = 63; phase_h = 63; end
                default: begin phase_w = pick_size(); phase_h = pick_size(); end
            endcase
            drain();
            write_reg(CFG_ACTIVE_WIDTH, phase_w);
            write_reg(CFG_ACTIVE_HEIGHT, phase_h);
            burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                issue_cmd(pick_cmd(), INDEX_W'($urandom_range(0, 31)),
                          INDEX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                          1'b0, 1'b0);
                idle_gap(gap_cycles(burst));
            end
        end

        // Let the last results arrive, then give the verdict.
        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/bcss_pkg.sv
rtl/bcss_ctrl.sv
rtl/bcss_datapath.sv
rtl/bitmap_circular_scroll_store_unit.sv
tb/tb_bitmap_circular_scroll_store_unit.sv
